/* rtl/min_year_extract_queue_macros.svh */
// Assertion macros used by the queue's top-level RTL.
`ifndef MIN_YEAR_EXTRACT_QUEUE_MACROS_SVH
`define MIN_YEAR_EXTRACT_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MYE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define MYE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/mye_pkg.sv */
// Types and constants of the min-year extract queue.
package mye_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] student_id;
        logic signed [31:0] score;
        logic signed [31:0] hours;
        logic signed [31:0] year;
    } t_in_req;

    typedef struct packed {
        logic        ok;
        logic [30:0] out_id;
        logic [30:0] out_score;
        logic [30:0] out_hours;
        logic [30:0] out_year;
        logic        now_empty;
        logic        now_full;
    } t_out_req;

    typedef struct packed {
        logic [30:0] id;
        logic [30:0] score;
        logic [30:0] hours;
        logic [30:0] year;
    } t_rec;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

endpackage

/* rtl/min_year_extract_queue.sv */
// Top level of the min-year extract queue: control, pointers and record RAM.
//
// Requests enter on the i_in_* channel (operation plus a record) and one
// response per request leaves on the o_out_* channel; both use valid/stall.
// Records live in one RAM of SLOTS entries; the queue holds up to SLOTS-1.
// Insert, clear, unused codes and remove on an empty queue answer in the cycle
// after acceptance. A non-empty remove scans the n stored entries for the
// smallest year, one RAM read per cycle, then moves the m entries behind the
// winner back one slot, one read and one write per cycle, and then answers.
// The single RAM read port paces both passes. One request is worked at a time.
// A request is taken while a response waits only if that response is taken
// in the same cycle; while the receiver stalls, the response holds and new
// requests are stalled. Reset empties the queue (head and tail to zero) and
// drops any pending response; RAM contents are not cleared.
module min_year_extract_queue
    import mye_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    localparam int PW = $clog2(SLOTS);
    localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);

    function automatic logic [PW-1:0] slot_next(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] slot_prev(input logic [PW-1:0] p);
        return (p == '0) ? LAST : p - 1'b1;
    endfunction

    t_state        r_state, n_state;
    logic [PW-1:0] r_head, n_head, r_tail, n_tail;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr, r_q_addr, n_q_addr, r_pos, n_pos;
    logic          r_q_vld, n_q_vld, r_first, n_first;
    t_rec          r_best, n_best;
    logic          r_out_valid, n_out_valid;
    t_out_req      r_out, n_out;

    logic          wr_en, rd_en, in_take, out_free, load, res_ok, bad;
    logic          is_empty, is_full;
    logic [PW-1:0] wr_addr, rd_addr;
    t_rec          wr_data, rd_data, res_rec, in_rec;

    mye_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_take    = i_in_valid && !o_in_stall;
    assign is_empty   = (r_head == r_tail);
    assign is_full    = (r_head == slot_next(r_tail));
    assign bad        = i_in_req.student_id[31] | i_in_req.score[31]
                      | i_in_req.hours[31] | i_in_req.year[31];
    assign in_rec     = '{id:    i_in_req.student_id[30:0],
                          score: i_in_req.score[30:0],
                          hours: i_in_req.hours[30:0],
                          year:  i_in_req.year[30:0]};

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_rd_ptr    = r_rd_ptr;
        n_q_addr    = r_q_addr;
        n_q_vld     = r_q_vld;
        n_first     = r_first;
        n_pos       = r_pos;
        n_best      = r_best;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_tail;
        wr_data     = in_rec;
        rd_en       = 1'b0;
        rd_addr     = r_rd_ptr;
        load        = 1'b0;
        res_ok      = 1'b0;
        res_rec     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    unique case (i_in_req.operation)
                        OP_INSERT: begin
                            load = 1'b1;
                            if (!is_full && !bad) begin
                                wr_en  = 1'b1;
                                n_tail = slot_next(r_tail);
                                res_ok = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (is_empty) begin
                                load = 1'b1;
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = r_head;
                                n_q_addr = r_head;
                                n_q_vld  = 1'b1;
                                n_rd_ptr = slot_next(r_head);
                                n_first  = 1'b1;
                                n_state  = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_head = '0;
                            n_tail = '0;
                            res_ok = 1'b1;
                            load   = 1'b1;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!r_q_vld) begin
                    n_rd_ptr = slot_next(r_pos);
                    n_state  = S_SHIFT;
                end else begin
                    if (r_first || (rd_data.year < r_best.year)) begin
                        n_best = rd_data;
                        n_pos  = r_q_addr;
                    end
                    n_first = 1'b0;
                    if (r_rd_ptr != r_tail) begin
                        rd_en    = 1'b1;
                        n_q_addr = r_rd_ptr;
                        n_q_vld  = 1'b1;
                        n_rd_ptr = slot_next(r_rd_ptr);
                    end else begin
                        n_q_vld = 1'b0;
                    end
                end
            end
            S_SHIFT: begin
                if (r_q_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = slot_prev(r_q_addr);
                    wr_data = rd_data;
                end
                if (r_rd_ptr != r_tail) begin
                    rd_en    = 1'b1;
                    n_q_addr = r_rd_ptr;
                    n_q_vld  = 1'b1;
                    n_rd_ptr = slot_next(r_rd_ptr);
                end else begin
                    n_q_vld = 1'b0;
                    if (!r_q_vld) begin
                        n_tail  = slot_prev(r_tail);
                        res_ok  = 1'b1;
                        res_rec = r_best;
                        load    = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
            n_out = '{ok:        res_ok,
                      out_id:    res_rec.id,
                      out_score: res_rec.score,
                      out_hours: res_rec.hours,
                      out_year:  res_rec.year,
                      now_empty: (n_head == n_tail),
                      now_full:  (n_head == slot_next(n_tail))};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_q_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_q_vld     <= n_q_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_q_addr <= n_q_addr;
        r_first  <= n_first;
        r_pos    <= n_pos;
        r_best   <= n_best;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

`include "min_year_extract_queue_macros.svh"

    `MYE_ASSERT_NOW(a_ptr_range, i_clk, i_rst_n, 1'b1,
        ({1'b0, r_head} < (PW+1)'(SLOTS)) && ({1'b0, r_tail} < (PW+1)'(SLOTS)))
    `MYE_ASSERT_NOW(a_no_rw_clash, i_clk, i_rst_n, wr_en && rd_en, wr_addr != rd_addr)
    `MYE_ASSERT_NOW(a_load_slot_free, i_clk, i_rst_n, load, out_free)
    `MYE_ASSERT_NEXT(a_remove_scans, i_clk, i_rst_n,
        in_take && (i_in_req.operation == OP_REMOVE) && !is_empty, r_state == S_SCAN)

endmodule

/* rtl/mye_ram.sv */
// Generic simple dual-port RAM with registered read.
module mye_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* dv/min_year_queue_checker.sv */
// Checker for the min-year extract queue: request predictor and response scoreboard.
`timescale 1ns / 1ps

module min_year_queue_checker
    import mye_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_in_req  i_in_req,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_req i_out_req,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_full_seen
);

    t_rec     slot_rec [SLOTS];
    int       head_idx;
    int       tail_idx;
    t_out_req due_rsp [$];
    t_out_req want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_full_seen  = 0;
        head_idx     = 0;
        tail_idx     = 0;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        $display("[%0t] mismatch %s: got %h, want %h", $realtime, what, got, exp_val);
        o_fail_count++;
    endtask

    function automatic t_out_req apply_queue_op(input t_in_req req);
        t_out_req    rsp;
        int          pos;
        int          i;
        logic [30:0] best;
        logic        bad;
        rsp = '0;
        case (req.operation)
            OP_INSERT: begin
                bad = req.student_id[31] | req.score[31] | req.hours[31] | req.year[31];
                if (!bad && head_idx != (tail_idx + 1) % SLOTS) begin
                    slot_rec[tail_idx].id    = req.student_id[30:0];
                    slot_rec[tail_idx].score = req.score[30:0];
                    slot_rec[tail_idx].hours = req.hours[30:0];
                    slot_rec[tail_idx].year  = req.year[30:0];
                    tail_idx = (tail_idx + 1) % SLOTS;
                    rsp.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (head_idx != tail_idx) begin
                    pos  = head_idx;
                    best = slot_rec[pos].year;
                    for (i = (head_idx + 1) % SLOTS; i != tail_idx; i = (i + 1) % SLOTS) begin
                        if (slot_rec[i].year < best) begin
                            pos  = i;
                            best = slot_rec[i].year;
                        end
                    end
                    rsp.out_id    = slot_rec[pos].id;
                    rsp.out_score = slot_rec[pos].score;
                    rsp.out_hours = slot_rec[pos].hours;
                    rsp.out_year  = slot_rec[pos].year;
                    for (i = (pos + 1) % SLOTS; i != tail_idx; i = (i + 1) % SLOTS)
                        slot_rec[(i + SLOTS - 1) % SLOTS] = slot_rec[i];
                    tail_idx = (tail_idx + SLOTS - 1) % SLOTS;
                    rsp.ok = 1'b1;
                end
            end
            OP_CLEAR: begin
                head_idx = 0;
                tail_idx = 0;
                rsp.ok   = 1'b1;
            end
            default: ;
        endcase
        rsp.now_empty = (head_idx == tail_idx);
        rsp.now_full  = (head_idx == (tail_idx + 1) % SLOTS);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_idx = 0;
            tail_idx = 0;
            due_rsp.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_rsp.size() == 0) begin
                    flag_mismatch("response with no request pending", 32'(i_out_req.ok), 0);
                end else begin
                    want = due_rsp.pop_front();
                    if (i_out_req.now_full)
                        o_full_seen++;
                    if (i_out_req.ok !== want.ok)
                        flag_mismatch("ok", 32'(i_out_req.ok), 32'(want.ok));
                    if (i_out_req.out_id !== want.out_id)
                        flag_mismatch("out_id", 32'(i_out_req.out_id), 32'(want.out_id));
                    if (i_out_req.out_score !== want.out_score)
                        flag_mismatch("out_score", 32'(i_out_req.out_score),
                                      32'(want.out_score));
                    if (i_out_req.out_hours !== want.out_hours)
                        flag_mismatch("out_hours", 32'(i_out_req.out_hours),
                                      32'(want.out_hours));
                    if (i_out_req.out_year !== want.out_year)
                        flag_mismatch("out_year", 32'(i_out_req.out_year),
                                      32'(want.out_year));
                    if (i_out_req.now_empty !== want.now_empty)
                        flag_mismatch("now_empty", 32'(i_out_req.now_empty),
                                      32'(want.now_empty));
                    if (i_out_req.now_full !== want.now_full)
                        flag_mismatch("now_full", 32'(i_out_req.now_full),
                                      32'(want.now_full));
                end
            end
            if (i_in_valid && !i_in_stall)
                due_rsp.push_back(apply_queue_op(i_in_req));
        end
        o_pending = due_rsp.size();
    end

endmodule

/* dv/tb.sv */
// Testbench top for the min-year extract queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import mye_pkg::*;

    localparam int         SLOTS          = 32;
    localparam int         RANDOM_REQS    = 850;
    localparam int         CALM_FROM      = 750;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_in_req  in_req;
    logic     out_valid;
    logic     out_stall;
    t_out_req out_req;

    int fail_count;
    int pending;
    int full_seen;
    int quiet_cycles;
    bit calm;
    int n_insert, n_remove, n_clear, n_unused;

    min_year_extract_queue #(.SLOTS(SLOTS)) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_req  (out_req)
    );

    min_year_queue_checker #(.SLOTS(SLOTS)) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_req    (in_req),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_req   (out_req),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_full_seen (full_seen)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        out_stall = 1'b0;
        forever begin
            repeat ($urandom_range(1, 24)) @(posedge clk);
            if (!calm && $urandom_range(0, 1) == 1) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic t_in_req make_req(input logic [1:0] op, input logic [31:0] id,
                                         input logic [31:0] sc, input logic [31:0] hr,
                                         input logic [31:0] yr);
        t_in_req r;
        r.operation  = op;
        r.student_id = id;
        r.score      = sc;
        r.hours      = hr;
        r.year       = yr;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($urandom_range(0, 15));
            default: return $urandom & 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic t_in_req rand_insert();
        t_in_req r;
        r = make_req(OP_INSERT, pick_value(), pick_value(), pick_value(),
                     ($urandom_range(0, 2) == 0) ? pick_value() : 32'($urandom_range(0, 20)));
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 4))
                0: r.student_id[31] = 1'b1;
                1: r.score[31]      = 1'b1;
                2: r.hours[31]      = 1'b1;
                3: r.year[31]       = 1'b1;
                default: begin
                    r.student_id = $urandom | 32'h8000_0000;
                    r.score      = $urandom | 32'h8000_0000;
                    r.hours      = $urandom | 32'h8000_0000;
                    r.year       = $urandom | 32'h8000_0000;
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_in_req rand_plain(input logic [1:0] op);
        return make_req(op, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic send_req(input t_in_req req);
        bit taken;
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_req   <= req;
        in_valid <= 1'b1;
        case (req.operation)
            OP_INSERT: n_insert++;
            OP_REMOVE: n_remove++;
            OP_CLEAR:  n_clear++;
            default:   n_unused++;
        endcase
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
    endtask

    initial begin
        int n;
        int roll;
        int fill_pct;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_req   = '0;
        calm     = 1'b0;
        fill_pct = 50;
        n_insert = 0;
        n_remove = 0;
        n_clear  = 0;
        n_unused = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(rand_plain(OP_REMOVE));
        send_req(rand_plain(OP_UNUSED));
        send_req(rand_plain(OP_CLEAR));
        send_req(make_req(OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF));
        send_req(make_req(OP_INSERT, 0, 0, 0, 0));
        send_req(make_req(OP_INSERT, 32'h8000_0000, 1, 2, 3));
        send_req(make_req(OP_INSERT, 1, 32'h8000_0000, 2, 3));
        send_req(make_req(OP_INSERT, 1, 2, 32'h8000_0000, 3));
        send_req(make_req(OP_INSERT, 1, 2, 3, 32'h8000_0000));
        send_req(make_req(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF));
        send_req(make_req(OP_INSERT, 5, 55, 555, 0));
        send_req(make_req(OP_INSERT, 9, 99, 999, 32'h7FFF_FFFF));
        send_req(rand_plain(OP_REMOVE));
        send_req(rand_plain(OP_REMOVE));
        send_req(rand_plain(OP_UNUSED));
        send_req(rand_plain(OP_REMOVE));
        send_req(rand_plain(OP_REMOVE));
        send_req(rand_plain(OP_REMOVE));
        send_req(make_req(OP_INSERT, 3, 4, 5, 6));
        send_req(make_req(OP_INSERT, 7, 8, 9, 2));
        send_req(rand_plain(OP_CLEAR));
        send_req(rand_plain(OP_REMOVE));

        for (n = 0; n < RANDOM_REQS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0:       fill_pct = 90;
                    1:       fill_pct = 55;
                    default: fill_pct = 20;
                endcase
            end
            calm = (n >= CALM_FROM);
            roll = $urandom_range(0, 99);
            if (roll < 3)
                send_req(rand_plain(OP_CLEAR));
            else if (roll < 5)
                send_req(rand_plain(OP_UNUSED));
            else if (roll < 5 + fill_pct * 95 / 100)
                send_req(rand_insert());
            else
                send_req(rand_plain(OP_REMOVE));
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (2 * SLOTS + 16) @(posedge clk);

        $display("covered %0d inserts, %0d removes, %0d clears, %0d unused codes",
                 n_insert, n_remove, n_clear, n_unused);
        $display("%0d responses reported a full queue, %0d mismatches", full_seen, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* min_year_extract_queue.f */
+incdir+rtl
rtl/mye_pkg.sv
rtl/mye_ram.sv
rtl/min_year_extract_queue.sv
dv/min_year_queue_checker.sv
dv/tb.sv
